### sv/vmb_pkg.sv
// ============================================================================
// VU meter ballistics: shared package
// Widths, item types, register codes and the dB interpolation table.
// ============================================================================
package vmb_pkg;

	localparam int CHANNELS     = 16;
	localparam int SAMPLE_WIDTH = 16;
	localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CHAN_W       = 4;
	localparam int IN_TDATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int LEVEL_W      = 14;
	localparam int OUT_TDATA_W  = ((LEVEL_W + 7) / 8) * 8;
	localparam int COEF_W       = 48;
	localparam int HALF_W       = COEF_W / 2;
	localparam int MUL_W        = 2 * COEF_W;
	localparam int FRAC_W       = 40;
	localparam int PROD_W       = MUL_W - FRAC_W;
	localparam int ACC_W        = PROD_W + 3;
	localparam int XSHIFT       = 45 - SAMPLE_WIDTH;
	localparam int OFFSET_W     = 15;
	localparam int OFFSET_RESET = 568;
	localparam int CFG_INDEX_W  = 3;
	localparam int POS_W        = $clog2(COEF_W);
	localparam int QUEUE_DEPTH  = 2;
	localparam int LEVEL_LOW    = -5120;
	localparam int LEVEL_HIGH   = 768;
	localparam int OCTAVE       = 24660;
	localparam int TABLE_W      = 15;

	// 20*log10(1 + i/16) in 1/4096 dB.
	localparam logic [TABLE_W-1:0] DB_TABLE [0:16] = '{
		15'd0, 15'd2157, 15'd4190, 15'd6114, 15'd7939, 15'd9675, 15'd11330,
		15'd12911, 15'd14425, 15'd15878, 15'd17273, 15'd18616, 15'd19910,
		15'd21158, 15'd22364, 15'd23531, 15'd24660
	};

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		coef_t a0_recip;
		coef_t a1;
		coef_t a2;
		coef_t b_outer;
		coef_t b_middle;
	} coef_set_t;

	typedef struct packed {
		logic                    ok;
		logic [CHAN_W-1:0]       channel;
		logic [SAMPLE_WIDTH-1:0] mag;
	} item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		coef_t             y;
	} lvl_req_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_A0_RECIP     = 3'd0,
		REG_A1           = 3'd1,
		REG_A2           = 3'd2,
		REG_B_OUTER      = 3'd3,
		REG_B_MIDDLE     = 3'd4,
		REG_LEVEL_OFFSET = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_TERMS,
		F_DRAIN,
		F_FINAL,
		F_SEND
	} filt_state_t;

endpackage

### sv/vmb_front.sv
// ============================================================================
// VU meter ballistics: front end
// Accepts items, checks the channel, rectifies the sample and queues it.
// ============================================================================
module vmb_front import vmb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,
	input  logic [CHAN_W-1:0]     s_tuser,
	output logic                  q_valid,
	input  logic                  q_ready,
	output item_t                 q_item
);

	localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	item_t                   mem_q [QUEUE_DEPTH];
	logic [QP_W-1:0]         wr_ptr_q;
	logic [QP_W-1:0]         rd_ptr_q;
	logic [QP_W:0]           count_q;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic [SAMPLE_WIDTH-1:0] mag;
	logic                    push;
	logic                    pop;
	item_t                   entry;

	assign sample   = $signed(s_tdata[SAMPLE_WIDTH-1:0]);
	assign mag      = sample[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-sample) : SAMPLE_WIDTH'(sample);
	assign s_tready = (count_q != (QP_W+1)'(QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];
	assign push     = s_tvalid & s_tready;
	assign pop      = q_valid & q_ready;

	always_comb begin
		entry.ok      = (32'(s_tuser) < CHANNELS);
		entry.channel = s_tuser;
		entry.mag     = mag;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/vmb_filter.sv
// ============================================================================
// VU meter ballistics: needle filter
// Per-channel second-order section on a shared partial-product multiplier.
// ============================================================================
module vmb_filter import vmb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  coef_set_t coef,
	input  logic      q_valid,
	output logic      q_ready,
	input  item_t     q_item,
	output logic      y_valid,
	input  logic      y_ready,
	output lvl_req_t  y_req
);

	localparam logic [2:0] T_X0 = 3'd0;
	localparam logic [2:0] T_X1 = 3'd1;
	localparam logic [2:0] T_X2 = 3'd2;
	localparam logic [2:0] T_Y1 = 3'd3;
	localparam logic [2:0] T_Y2 = 3'd4;

	typedef struct packed {
		logic [SAMPLE_WIDTH-1:0] x1;
		logic [SAMPLE_WIDTH-1:0] x2;
		coef_t                   y1;
		coef_t                   y2;
	} hist_t;

	filt_state_t state_q, state_d;
	hist_t       hist_q [CHANNELS];
	hist_t       cur_q;
	logic [CH_W-1:0]         ch_q;
	logic [CHAN_W-1:0]       chan_q;
	logic [SAMPLE_WIDTH-1:0] x0_q;
	logic [2:0]              cnt_q;
	logic signed [ACC_W-1:0] acc_q;
	coef_t                   y_q;

	coef_t mul_a, mul_b;
	logic  mul_go, mul_neg, mul_fin;
	logic signed [HALF_W:0] a_hi, a_lo, b_hi, b_lo;

	logic signed [2*HALF_W+1:0] pp_hh_s1, pp_hl_s1, pp_lh_s1, pp_ll_s1;
	logic v_s1_q, neg_s1_q, fin_s1_q;
	logic signed [MUL_W-1:0]  full_prod;
	logic signed [PROD_W-1:0] prod_s2;
	logic v_s2_q, neg_s2_q, fin_s2_q;
	coef_t y_sat;

	function automatic coef_t x_align(input logic [SAMPLE_WIDTH-1:0] m);
		return coef_t'(COEF_W'(m) << XSHIFT);
	endfunction

	function automatic coef_t sat_coef(input logic signed [ACC_W-1:0] v);
		logic all_ones;
		logic all_zeros;
		all_ones  = &v[ACC_W-1:COEF_W-1];
		all_zeros = ~|v[ACC_W-1:COEF_W-1];
		if (all_ones || all_zeros) begin
			return v[COEF_W-1:0];
		end else if (v[ACC_W-1]) begin
			return {1'b1, {(COEF_W-1){1'b0}}};
		end
		return {1'b0, {(COEF_W-1){1'b1}}};
	endfunction

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (q_valid) begin
					state_d = q_item.ok ? F_TERMS : F_SEND;
				end
			end
			F_TERMS: begin
				if (cnt_q == T_Y2) begin
					state_d = F_DRAIN;
				end
			end
			F_DRAIN: begin
				if (!v_s1_q && !v_s2_q) begin
					state_d = F_FINAL;
				end
			end
			F_FINAL: begin
				if (v_s2_q && fin_s2_q) begin
					state_d = F_SEND;
				end
			end
			F_SEND: begin
				if (y_ready) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		q_ready = 1'b0;
		y_valid = 1'b0;
		mul_go  = 1'b0;
		mul_neg = 1'b0;
		mul_fin = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			F_IDLE: q_ready = 1'b1;
			F_TERMS: begin
				mul_go = 1'b1;
				case (cnt_q)
					T_X0: begin
						mul_a = coef.b_outer;
						mul_b = x_align(x0_q);
					end
					T_X1: begin
						mul_a = coef.b_middle;
						mul_b = x_align(cur_q.x1);
					end
					T_X2: begin
						mul_a = coef.b_outer;
						mul_b = x_align(cur_q.x2);
					end
					T_Y1: begin
						mul_a   = coef.a1;
						mul_b   = cur_q.y1;
						mul_neg = 1'b1;
					end
					T_Y2: begin
						mul_a   = coef.a2;
						mul_b   = cur_q.y2;
						mul_neg = 1'b1;
					end
					default: mul_go = 1'b0;
				endcase
			end
			F_DRAIN: begin
				if (!v_s1_q && !v_s2_q) begin
					mul_go  = 1'b1;
					mul_fin = 1'b1;
					mul_a   = coef.a0_recip;
					mul_b   = sat_coef(acc_q);
				end
			end
			F_FINAL: ;
			F_SEND:  y_valid = 1'b1;
			default: ;
		endcase
	end

	assign y_req.channel = chan_q;
	assign y_req.y       = y_q;

	// Split each operand into a signed upper half and an unsigned lower half.
	assign a_hi = {mul_a[COEF_W-1], mul_a[COEF_W-1:HALF_W]};
	assign a_lo = {1'b0, mul_a[HALF_W-1:0]};
	assign b_hi = {mul_b[COEF_W-1], mul_b[COEF_W-1:HALF_W]};
	assign b_lo = {1'b0, mul_b[HALF_W-1:0]};

	assign full_prod = (MUL_W'(pp_hh_s1) <<< (2*HALF_W))
		+ (MUL_W'(pp_hl_s1) <<< HALF_W)
		+ (MUL_W'(pp_lh_s1) <<< HALF_W)
		+ MUL_W'(pp_ll_s1);
	assign y_sat = sat_coef(ACC_W'(prod_s2));

	always_ff @(posedge clk) begin
		pp_hh_s1 <= a_hi * b_hi;
		pp_hl_s1 <= a_hi * b_lo;
		pp_lh_s1 <= a_lo * b_hi;
		pp_ll_s1 <= a_lo * b_lo;
		neg_s1_q <= mul_neg;
		fin_s1_q <= mul_fin;
		prod_s2  <= full_prod[MUL_W-1:FRAC_W];
		neg_s2_q <= neg_s1_q;
		fin_s2_q <= fin_s1_q;
		if (state_q == F_IDLE && q_valid) begin
			ch_q   <= CH_W'(q_item.channel);
			chan_q <= q_item.channel;
			x0_q   <= q_item.mag;
			cur_q  <= hist_q[CH_W'(q_item.channel)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
			acc_q   <= '0;
			y_q     <= '0;
			v_s1_q  <= 1'b0;
			v_s2_q  <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			v_s1_q  <= mul_go;
			v_s2_q  <= v_s1_q;
			if (state_q == F_IDLE) begin
				cnt_q <= '0;
				acc_q <= '0;
				y_q   <= '0;
			end else if (state_q == F_TERMS) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (v_s2_q && !fin_s2_q) begin
				acc_q <= neg_s2_q ? acc_q - ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
			end
			if (v_s2_q && fin_s2_q) begin
				y_q        <= y_sat;
				hist_q[ch_q] <= '{x1: x0_q, x2: cur_q.x1, y1: y_sat, y2: cur_q.y1};
			end
		end
	end

endmodule

### sv/vmb_level.sv
// ============================================================================
// VU meter ballistics: level converter
// Turns a filter output into clamped dB by leading one and table lookup.
// ============================================================================
module vmb_level import vmb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic signed [OFFSET_W-1:0] level_offset,
	input  logic                   y_valid,
	output logic                   y_ready,
	input  lvl_req_t               y_req,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic [CHAN_W-1:0]      m_tuser
);

	localparam logic signed [19:0] LOW20  = 20'(LEVEL_LOW);
	localparam logic signed [19:0] HIGH20 = 20'(LEVEL_HIGH);

	logic v_s1_q, v_s2_q, v_s3_q, v_s4_q, out_valid_q;
	coef_t             y_s1, y_s2;
	logic [CHAN_W-1:0] ch_s1, ch_s2, ch_s3, ch_s4, chan_q;
	logic [POS_W-1:0]  p_s2, p_s3, p_s4;
	logic              pos_s2, pos_s3, pos_s4;
	logic [15:0]       r_s3;
	logic [TABLE_W-1:0] base_s4, interp_s4;
	logic [LEVEL_W-1:0] level_q;

	logic [COEF_W-2:0]  norm;
	logic [3:0]         idx;
	logic [TABLE_W-1:0] diff;
	logic [TABLE_W+11:0] slope;
	logic signed [7:0]  p_rel;
	logic signed [23:0] oct_term, total;
	logic signed [19:0] lvl_wide, lvl_clamp;
	logic               out_free;

	function automatic logic [POS_W-1:0] lead_one(input logic [COEF_W-2:0] u);
		logic [POS_W-1:0] p;
		p = '0;
		for (int i = 0; i < COEF_W - 1; i++) begin
			if (u[i]) begin
				p = POS_W'(i);
			end
		end
		return p;
	endfunction

	assign y_ready  = !(v_s1_q || v_s2_q || v_s3_q || v_s4_q);
	assign out_free = !out_valid_q || m_tready;

	assign norm  = y_s2[COEF_W-2:0] << (POS_W'(COEF_W - 2) - p_s2);
	assign idx   = r_s3[15:12];
	assign diff  = DB_TABLE[5'(idx) + 5'd1] - DB_TABLE[5'(idx)];
	assign slope = (TABLE_W+12)'(diff) * (TABLE_W+12)'(r_s3[11:0]);

	always_comb begin
		p_rel    = $signed({2'b00, p_s4}) - 8'sd40;
		oct_term = 24'(p_rel) * 24'(OCTAVE);
		total    = oct_term + 24'($signed({1'b0, base_s4})) + 24'($signed({1'b0, interp_s4}))
			+ (24'(level_offset) <<< 4) + 24'sd8;
		lvl_wide = total[23:4];
		if (!pos_s4 || lvl_wide < LOW20) begin
			lvl_clamp = LOW20;
		end else if (lvl_wide > HIGH20) begin
			lvl_clamp = HIGH20;
		end else begin
			lvl_clamp = lvl_wide;
		end
	end

	always_ff @(posedge clk) begin
		if (y_valid && y_ready) begin
			y_s1  <= y_req.y;
			ch_s1 <= y_req.channel;
		end
		p_s2   <= lead_one(y_s1[COEF_W-2:0]);
		pos_s2 <= !y_s1[COEF_W-1] && (y_s1 != '0);
		y_s2   <= y_s1;
		ch_s2  <= ch_s1;
		r_s3   <= norm[COEF_W-3 -: 16];
		p_s3   <= p_s2;
		pos_s3 <= pos_s2;
		ch_s3  <= ch_s2;
		if (!v_s4_q || out_free) begin
			base_s4   <= DB_TABLE[5'(idx)];
			interp_s4 <= slope[TABLE_W+11:12];
			p_s4      <= p_s3;
			pos_s4    <= pos_s3;
			ch_s4     <= ch_s3;
		end
		if (v_s4_q && out_free) begin
			level_q <= LEVEL_W'(lvl_clamp);
			chan_q  <= ch_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			v_s3_q      <= 1'b0;
			v_s4_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1_q <= y_valid && y_ready;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q;
			v_s4_q <= v_s3_q || (v_s4_q && !out_free);
			if (v_s4_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(level_q);
	assign m_tuser  = chan_q;

endmodule

### sv/vu_meter_ballistics.sv
// ============================================================================
// VU meter ballistics
// Per-channel needle filter with a clamped dB read-out.
// ============================================================================
// Each item is one signed sample with its channel number in tuser; each result
// item gives that channel and the meter level in 1/256 dB, clamped to -20..+3
// dB, in the order the items came in. A two-item queue takes input items at
// one per cycle while it has room. The filter takes one item at a time: six
// products go through one multiplier built from four partial products, each
// product passing the partial-product and product registers, and the scaling
// product waits on the sum of the other five. Items for a channel beyond the
// configured count skip the products. The level converter works in the shadow
// of the next item, so the filter takes a new item while it finishes the last.
// Write the coefficients and the level offset only while no item is in flight.
module vu_meter_ballistics import vmb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // sample
	input  logic [CHAN_W-1:0]      s_tuser,   // channel
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // level_db, zero padding
	output logic [CHAN_W-1:0]      m_tuser,   // out_channel
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]      cfg_data
);

	coef_set_t coef_q;
	logic signed [OFFSET_W-1:0] offset_q;

	logic     q_valid, q_ready;
	item_t    q_item;
	logic     y_valid, y_ready;
	lvl_req_t y_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q   <= '0;
			offset_q <= OFFSET_W'(OFFSET_RESET);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_A0_RECIP:     coef_q.a0_recip <= cfg_data;
				REG_A1:           coef_q.a1       <= cfg_data;
				REG_A2:           coef_q.a2       <= cfg_data;
				REG_B_OUTER:      coef_q.b_outer  <= cfg_data;
				REG_B_MIDDLE:     coef_q.b_middle <= cfg_data;
				REG_LEVEL_OFFSET: offset_q        <= cfg_data[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	vmb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	vmb_filter u_filter (
		.clk     (clk),
		.arst_n  (arst_n),
		.coef    (coef_q),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item),
		.y_valid (y_valid),
		.y_ready (y_ready),
		.y_req   (y_req)
	);

	vmb_level u_level (
		.clk          (clk),
		.arst_n       (arst_n),
		.level_offset (offset_q),
		.y_valid      (y_valid),
		.y_ready      (y_ready),
		.y_req        (y_req),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser)
	);

endmodule

### sv/vmb_checker.sv
// ============================================================================
// VU meter ballistics: port checker
// Checks top-level ports: result range, stall holding, padding, item counts.
// ============================================================================
module vmb_checker import vmb_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [CHAN_W-1:0]      m_tuser
);

	localparam int CAPACITY = QUEUE_DEPTH + 3;

	logic [3:0] pending_q;
	logic signed [LEVEL_W-1:0] level;

	assign level = $signed(m_tdata[LEVEL_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if ((s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
			pending_q <= pending_q + 1'b1;
		end else if (!(s_tvalid && s_tready) && (m_tvalid && m_tready)) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Result item changed while stalled.");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (level >= LEVEL_W'(LEVEL_LOW)) && (level <= LEVEL_W'(LEVEL_HIGH)))
		else $error("Level outside the meter range.");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:LEVEL_W] == '0)
		else $error("Padding bits of the result are not zero.");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != '0)
		else $error("Result item without a pending input item.");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'(CAPACITY))
		else $error("More items in flight than the block can hold.");

endmodule

bind vu_meter_ballistics vmb_checker u_checker (.*);

### tb/vu_meter_ballistics_tb.sv
// ============================================================================
// VU meter ballistics testbench
// Sends sample items over the input stream, writes the needle coefficients
// and the level offset between phases, and checks level items against their
// row's level or an in-bench needle filter and dB converter. A short table
// covers extremes first; random phases follow, most with both sides idling.
// ============================================================================
module vu_meter_ballistics_tb;
	import vmb_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 100;
	localparam int SETTLE_CYCLES = 20;
	localparam int DIRECTED_ROWS = 32;

	localparam int DB_FLOOR    = -5120;
	localparam int DB_CEIL     = 768;
	localparam int OCTAVE_STEP = 24660;
	localparam int LOG_STEPS [17] = '{
		0, 2157, 4190, 6114, 7939, 9675, 11330, 12911, 14425,
		15878, 17273, 18616, 19910, 21158, 22364, 23531, 24660
	};

	localparam logic [CFG_INDEX_W-1:0] NO_REG      = '0;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam logic [COEF_W-1:0] Q_ONE = 48'h0100_0000_0000;
	localparam logic [COEF_W-1:0] Q_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [COEF_W-1:0] Q_MIN = 48'h8000_0000_0000;
	localparam logic [COEF_W-1:0] OFFSET_MIN = 48'hFFFF_FFFF_C000;
	localparam logic [COEF_W-1:0] OFFSET_MAX = 48'h0000_0000_3FFF;

	// Needle with a double pole at 0.9 and a DC gain of 0.2.
	localparam coef_t NEEDLE_BO = 48'sd549755814;
	localparam coef_t NEEDLE_BM = 48'sd1099511628;
	localparam coef_t NEEDLE_A1 = -48'sd1979120929997;
	localparam coef_t NEEDLE_A2 = 48'sd890604418499;

	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t               kind;
		logic [CFG_INDEX_W-1:0]  index;
		logic [COEF_W-1:0]       value;
		logic [CHAN_W-1:0]       channel;
		logic [SAMPLE_WIDTH-1:0] sample;
		logic                    typed;
		logic signed [LEVEL_W-1:0] level;
	} stim_row_t;

	typedef struct packed {
		logic [CHAN_W-1:0]      channel;
		logic [OUT_TDATA_W-1:0] tdata;
	} reading_t;

	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{ROW_ITEM, NO_REG, 48'h0, 4'd0, 16'h0000, 1'b1, -14'sd5120},
		'{ROW_ITEM, NO_REG, 48'h0, 4'd15, 16'h7FFF, 1'b1, -14'sd5120},
		'{ROW_ITEM, NO_REG, 48'h0, 4'd7, 16'h8000, 1'b1, -14'sd5120},
		'{ROW_CFG, REG_A0_RECIP, Q_ONE, 4'd0, 16'h0000, 1'b0, 14'sd0},
		'{ROW_CFG, REG_B_OUTER, Q_ONE, 4'd0, 16'h0000, 1'b0, 14'sd0},
		'{ROW_CFG, REG_B_MIDDLE, 48'h0, 4'd0, 16'h0000, 1'b0, 14'sd0},
		'{ROW_CFG, REG_A1, 48'h0, 4'd0, 16'h0000, 1'b0, 14'sd0},
		'{ROW_CFG, REG_A2, 48'h0, 4'd0, 16'h0000, 1'b0, 14'sd0},
		'{ROW_CFG, REG_LEVEL_OFFSET, 48'h0, 4'd0, 16'h0000, 1'b0, 14'sd0},
		'{ROW_ITEM, NO_REG, 48'h0, 4'd1, 16'h0800, 1'b1, 14'sd0},
		'{ROW_ITEM, NO_REG, 48'h0, 4'd1, 16'hF800, 1'b1, 14'sd0},
		'{ROW_ITEM, NO_REG, 48'h0, 4'd1, 16'h0000, 1'b1, 14'sd0},
		'{ROW_ITEM, NO_REG, 48'h0, 4'd2, 16'h8000, 1'b1, 14'sd768},
		'{ROW_CFG, REG_LEVEL_OFFSET, OFFSET_MIN, 4'd0, 16'h0000, 1'b0, 14'sd0},
		'{ROW_ITEM, NO_REG, 48'h0, 4'd3, 16'h7FFF, 1'b1, -14'sd5120},
		'{ROW_CFG, REG_LEVEL_OFFSET, OFFSET_MAX, 4'd0, 16'h0000, 1'b0, 14'sd0},
		'{ROW_ITEM, NO_REG, 48'h0, 4'd4, 16'h0001, 1'b0, 14'sd0},
		'{ROW_CFG, REG_SPARE_6, 48'hFFFF_FFFF_FFFF, 4'd0, 16'h0000, 1'b0, 14'sd0},
		'{ROW_CFG, REG_SPARE_7, 48'h5555_5555_5555, 4'd0, 16'h0000, 1'b0, 14'sd0},
		'{ROW_ITEM, NO_REG, 48'h0, 4'd4, 16'hFFFF, 1'b0, 14'sd0},
		'{ROW_CFG, REG_A0_RECIP, Q_MAX, 4'd0, 16'h0000, 1'b0, 14'sd0},
		'{ROW_CFG, REG_B_OUTER, Q_MAX, 4'd0, 16'h0000, 1'b0, 14'sd0},
		'{ROW_CFG, REG_B_MIDDLE, Q_MIN, 4'd0, 16'h0000, 1'b0, 14'sd0},
		'{ROW_CFG, REG_A1, Q_MIN, 4'd0, 16'h0000, 1'b0, 14'sd0},
		'{ROW_CFG, REG_A2, Q_MAX, 4'd0, 16'h0000, 1'b0, 14'sd0},
		'{ROW_ITEM, NO_REG, 48'h0, 4'd5, 16'h7FFF, 1'b1, 14'sd768},
		'{ROW_ITEM, NO_REG, 48'h0, 4'd5, 16'h0000, 1'b0, 14'sd0},
		'{ROW_ITEM, NO_REG, 48'h0, 4'd5, 16'h8000, 1'b0, 14'sd0},
		'{ROW_CFG, REG_A0_RECIP, Q_MIN, 4'd0, 16'h0000, 1'b0, 14'sd0},
		'{ROW_ITEM, NO_REG, 48'h0, 4'd6, 16'h8000, 1'b1, -14'sd5120},
		'{ROW_CFG, REG_LEVEL_OFFSET, 48'hA5A5_A5A5_0238, 4'd0, 16'h0000, 1'b0, 14'sd0},
		'{ROW_ITEM, NO_REG, 48'h0, 4'd8, 16'h1234, 1'b0, 14'sd0}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [CHAN_W-1:0]      s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [CHAN_W-1:0]      m_tuser;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [COEF_W-1:0]      cfg_data;

	logic hold_req;
	logic rx_stalls_on;
	bit   tx_gaps_on;
	int   mismatches;

	coef_t k_a0, k_a1, k_a2, k_bo, k_bm;
	logic signed [OFFSET_W-1:0] k_offset;
	logic [SAMPLE_WIDTH-1:0] x_hist1 [CHANNELS];
	logic [SAMPLE_WIDTH-1:0] x_hist2 [CHANNELS];
	coef_t y_hist1 [CHANNELS];
	coef_t y_hist2 [CHANNELS];

	reading_t levels_due [$];

	vu_meter_ballistics dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	function automatic logic signed [55:0] q40_mul(coef_t a, coef_t b);
		logic signed [95:0] full;
		full = a * b;
		return 56'(full >>> FRAC_W);
	endfunction

	function automatic coef_t clip48(logic signed [59:0] v);
		if (v[59:47] == {13{v[59]}}) begin
			return v[47:0];
		end
		return v[59] ? Q_MIN : Q_MAX;
	endfunction

	function automatic logic signed [LEVEL_W-1:0] db_of(coef_t y,
			logic signed [OFFSET_W-1:0] offset);
		int          p;
		int          idx;
		logic [63:0] u;
		logic [15:0] r;
		longint      frac;
		longint      total;
		longint      lvl;
		if (y <= 0) begin
			return LEVEL_W'(DB_FLOOR);
		end
		u = {16'b0, y};
		p = 46;
		while (p > 0 && u[p] == 1'b0) begin
			p--;
		end
		if (p >= 16) begin
			r = 16'(u >> (p - 16));
		end else begin
			r = 16'(u << (16 - p));
		end
		idx = int'(r[15:12]);
		frac = LOG_STEPS[idx]
			+ ((longint'(LOG_STEPS[idx + 1] - LOG_STEPS[idx]) * longint'(r[11:0])) >>> 12);
		total = longint'(p - 40) * OCTAVE_STEP + frac + longint'(offset) * 16 + 8;
		lvl = total >>> 4;
		if (lvl < DB_FLOOR) begin
			lvl = DB_FLOOR;
		end
		if (lvl > DB_CEIL) begin
			lvl = DB_CEIL;
		end
		return LEVEL_W'(lvl);
	endfunction

	// Runs one sample through the channel's needle and returns the meter level.
	function automatic logic signed [LEVEL_W-1:0] advance_needle(logic [CHAN_W-1:0] ch,
			logic [SAMPLE_WIDTH-1:0] smp);
		logic [SAMPLE_WIDTH-1:0] mag;
		coef_t                   x0, x1, x2, y;
		logic signed [59:0]      acc;
		mag = smp[SAMPLE_WIDTH-1] ? (~smp + 1'b1) : smp;
		x0 = coef_t'(mag) << (45 - SAMPLE_WIDTH);
		x1 = coef_t'(x_hist1[ch]) << (45 - SAMPLE_WIDTH);
		x2 = coef_t'(x_hist2[ch]) << (45 - SAMPLE_WIDTH);
		acc = q40_mul(k_bo, x0) + q40_mul(k_bm, x1) + q40_mul(k_bo, x2)
			- q40_mul(k_a1, y_hist1[ch]) - q40_mul(k_a2, y_hist2[ch]);
		y = clip48(60'(q40_mul(k_a0, clip48(acc))));
		x_hist2[ch] = x_hist1[ch];
		x_hist1[ch] = mag;
		y_hist2[ch] = y_hist1[ch];
		y_hist1[ch] = y;
		return db_of(y, k_offset);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 0;
		end
		if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [COEF_W-1:0] val);
		s_tvalid <= 1'b0;
		while (levels_due.size() != 0) begin
			@(posedge clk);
		end
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_A0_RECIP:     k_a0 = val;
			REG_A1:           k_a1 = val;
			REG_A2:           k_a2 = val;
			REG_B_OUTER:      k_bo = val;
			REG_B_MIDDLE:     k_bm = val;
			REG_LEVEL_OFFSET: k_offset = val[OFFSET_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_sample(logic [CHAN_W-1:0] ch, logic [SAMPLE_WIDTH-1:0] smp,
			logic typed, logic signed [LEVEL_W-1:0] typed_level);
		int                        gap;
		logic signed [LEVEL_W-1:0] lvl;
		reading_t                  due;
		cfg_we <= 1'b0;
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= ch;
		do begin
			@(negedge clk);
		end while (!s_tready);
		@(posedge clk);
		lvl = advance_needle(ch, smp);
		due.channel = ch;
		due.tdata = {{(OUT_TDATA_W - LEVEL_W){1'b0}}, typed ? typed_level : lvl};
		levels_due.push_back(due);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// The output side idles at random while stalls are enabled; once it holds off
	// long enough to back up the input.
	initial begin
		int stall_left;
		bit hold_done;
		stall_left = 0;
		hold_done  = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (stall_left == 0 && rx_stalls_on && $urandom_range(0, 2) == 0) begin
					stall_left = pick_gap();
				end
				if (stall_left > 0) begin
					m_tready <= 1'b0;
					stall_left--;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	// Level items are sampled on the falling edge before the edge that accepts them.
	initial begin
		reading_t want;
		forever begin
			@(negedge clk);
			if (m_tvalid && m_tready) begin
				if (levels_due.size() == 0) begin
					$display("%0t: unexpected level item, expected none, got channel %0d data %h",
						$time, m_tuser, m_tdata);
					mismatches++;
				end else begin
					want = levels_due.pop_front();
					if (m_tuser !== want.channel) begin
						$display("%0t: out_channel expected %0d, got %0d",
							$time, want.channel, m_tuser);
						mismatches++;
					end
					if (m_tdata !== want.tdata) begin
						$display("%0t: level_db expected %0d (%h), got %0d (%h)", $time,
							$signed(want.tdata[LEVEL_W-1:0]), want.tdata,
							$signed(m_tdata[LEVEL_W-1:0]), m_tdata);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		int                      i;
		int                      phase;
		int                      n;
		logic [CHAN_W-1:0]       ch;
		logic [SAMPLE_WIDTH-1:0] smp;
		coef_t                   a0, a1, a2, bo, bm;
		logic [COEF_W-1:0]       off;
		mismatches = 0;
		tx_gaps_on = 1'b1;
		arst_n       <= 1'b0;
		s_tvalid     <= 1'b0;
		s_tdata      <= '0;
		s_tuser      <= '0;
		cfg_we       <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		hold_req     <= 1'b0;
		rx_stalls_on <= 1'b1;
		k_a0 = '0;
		k_a1 = '0;
		k_a2 = '0;
		k_bo = '0;
		k_bm = '0;
		k_offset = OFFSET_W'(OFFSET_RESET);
		for (i = 0; i < CHANNELS; i++) begin
			x_hist1[i] = '0;
			x_hist2[i] = '0;
			y_hist1[i] = '0;
			y_hist2[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < DIRECTED_ROWS; i++) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				write_reg(DIRECTED[i].index, DIRECTED[i].value);
			end else begin
				send_sample(DIRECTED[i].channel, DIRECTED[i].sample,
					DIRECTED[i].typed, DIRECTED[i].level);
			end
		end

		for (phase = 0; phase < PHASES; phase++) begin
			a0 = Q_ONE + (coef_t'($signed($urandom)) >>> 8);
			bo = NEEDLE_BO + (coef_t'($signed($urandom)) >>> 8);
			bm = NEEDLE_BM + (coef_t'($signed($urandom)) >>> 8);
			a1 = NEEDLE_A1 + (coef_t'($signed($urandom)) >>> 8);
			a2 = NEEDLE_A2 + (coef_t'($signed($urandom)) >>> 8);
			off = COEF_W'({$urandom, $urandom});
			off[OFFSET_W-1:0] = OFFSET_W'(int'($urandom_range(0, 4000)) - 2000);
			if (phase == 2) begin
				a0 = coef_t'({$urandom, $urandom});
				bo = coef_t'({$urandom, $urandom});
				bm = coef_t'({$urandom, $urandom});
				a1 = coef_t'({$urandom, $urandom});
				a2 = coef_t'({$urandom, $urandom});
			end else if (phase == 4) begin
				a0 = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
				bo = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
				bm = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
				a1 = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
				a2 = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
				off[OFFSET_W-1:0] = $urandom_range(0, 1) ? OFFSET_MIN[OFFSET_W-1:0]
					: OFFSET_MAX[OFFSET_W-1:0];
			end
			write_reg(REG_A0_RECIP, a0);
			write_reg(REG_A1, a1);
			write_reg(REG_A2, a2);
			write_reg(REG_B_OUTER, bo);
			write_reg(REG_B_MIDDLE, bm);
			write_reg(REG_LEVEL_OFFSET, off);
			write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
				COEF_W'({$urandom, $urandom}));
			tx_gaps_on = (phase != 1);
			rx_stalls_on <= (phase != 1);

			for (n = 0; n < PHASE_ITEMS; n++) begin
				ch = $urandom_range(0, 1) ? CHAN_W'($urandom_range(0, 3))
					: CHAN_W'($urandom_range(0, 15));
				if ($urandom_range(0, 9) == 0) begin
					case ($urandom_range(0, 3))
						0: smp = 16'h7FFF;
						1: smp = 16'h8000;
						2: smp = 16'h0000;
						default: smp = 16'hFFFF;
					endcase
				end else begin
					smp = SAMPLE_WIDTH'($signed(SAMPLE_WIDTH'($urandom)) >>> $urandom_range(0, 12));
				end
				if (phase == 1 && n == 10) begin
					hold_req <= 1'b1;
				end
				send_sample(ch, smp, 1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		while (levels_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
